// File: src/bmd_pkg.sv
// shared types and constants for the box minimum-distance core
// depends on nothing; every other file refers to it by scoped names
`timescale 1ns / 1ps

package bmd_pkg;

   localparam int COORD_BITS = 16;
   localparam int GAP_BITS   = 16;                 // magnitude of a positive gap
   localparam int PROD_BITS  = 2 * GAP_BITS;       // gap squared
   localparam int SUM_BITS   = 36;
   localparam int ROOT_BITS  = 26;
   localparam int FRAC_SHIFT = 16;                 // q8 root = sqrt(sum << 16)
   localparam int RAD_BITS   = SUM_BITS + FRAC_SHIFT;
   localparam int REM_BITS   = ROOT_BITS + 3;
   localparam int MUL_DIGITS = GAP_BITS / 2;       // radix-4 digits
   localparam int MUL_CNT_BITS  = $clog2(MUL_DIGITS);
   localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);

   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   typedef struct packed {
      logic signed [COORD_BITS-1:0] box_a_low;
      logic signed [COORD_BITS-1:0] box_a_high;
      logic signed [COORD_BITS-1:0] box_b_low;
      logic signed [COORD_BITS-1:0] box_b_high;
      logic                         last_dim;
   } req_data_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]  squared_distance;
      logic [ROOT_BITS-1:0] distance_q8;
      logic                 overlap;
   } rsp_data_type;

   // handshake between the sequencer and a serial unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// File: src/box_min_distance_overlap_core.sv
// top level of the box minimum-distance / overlap core
// depends on bmd_pkg, bmd_mul, bmd_sqrt
//
//   channel   dir   handshake            payload
//   req_      in    req_valid/req_stall  bmd_pkg::req_data_type  (one dimension)
//   rsp_      out   rsp_valid/rsp_stall  bmd_pkg::rsp_data_type  (one per box pair)
//
// a request that is not the last dimension goes through capture and the
// 8 radix-4 steps of the serial squarer, then accumulate and ready again
// the last dimension then runs the bit-serial square root, one bit
// a cycle, and loads the response register
// reset (synchronous) clears the sequencer, the running sum and the apart flag
// the response sits in an output register; new requests are taken while it
// waits, and only a finished root that finds it still full holds the block
`timescale 1ns / 1ps

module box_min_distance_overlap_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bmd_pkg::req_data_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bmd_pkg::rsp_data_type  rsp_data
);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a request
   localparam logic [1:0] S_MUL  = 2'd1;   // squaring the gap
   localparam logic [1:0] S_ROOT = 2'd2;   // taking the root of the finished sum
   localparam logic [1:0] S_HOLD = 2'd3;   // root done, output register still full

   logic [1:0]                         state_ff, state_in;
   logic [bmd_pkg::SUM_BITS-1:0]       sum_ff, sum_in;
   logic                               apart_ff, apart_in;
   logic                               pos_ff, pos_in;
   logic                               last_ff, last_in;
   logic [bmd_pkg::SUM_BITS-1:0]       res_sum_ff, res_sum_in;
   logic                               res_overlap_ff, res_overlap_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   bmd_pkg::rsp_data_type              rsp_data_ff, rsp_data_in;

   logic                               req_take;
   logic                               out_free;
   logic signed [bmd_pkg::COORD_BITS-1:0] lo_max;
   logic signed [bmd_pkg::COORD_BITS-1:0] hi_min;
   logic signed [bmd_pkg::COORD_BITS:0]   gap;
   logic                               gap_pos;
   logic [bmd_pkg::SUM_BITS:0]         sum_wide;
   logic [bmd_pkg::SUM_BITS-1:0]       sum_next;
   logic                               apart_next;
   logic                               mul_start;
   logic                               root_start;
   bmd_pkg::unit_status_type           mul_status;
   bmd_pkg::unit_status_type           root_status;
   logic [bmd_pkg::PROD_BITS-1:0]      product;
   logic [bmd_pkg::ROOT_BITS-1:0]      root;

   assign req_take = req_valid && !req_stall;
   // output register can take a new response this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // gap = max(lows) - min(highs), one bit wider so it never wraps
   assign lo_max  = (req_data.box_a_low > req_data.box_b_low) ?
                    req_data.box_a_low : req_data.box_b_low;
   assign hi_min  = (req_data.box_a_high < req_data.box_b_high) ?
                    req_data.box_a_high : req_data.box_b_high;
   assign gap     = {lo_max[bmd_pkg::COORD_BITS-1], lo_max}
                    - {hi_min[bmd_pkg::COORD_BITS-1], hi_min};
   assign gap_pos = !gap[bmd_pkg::COORD_BITS] && (gap != '0);

   // saturating accumulate of the finished square
   assign sum_wide = {1'b0, sum_ff}
                     + {{(bmd_pkg::SUM_BITS+1-bmd_pkg::PROD_BITS){1'b0}}, product};
   always_comb begin
      if (!pos_ff) begin
         sum_next = sum_ff;
      end else if (sum_wide[bmd_pkg::SUM_BITS]) begin
         sum_next = bmd_pkg::SUM_MAX;
      end else begin
         sum_next = sum_wide[bmd_pkg::SUM_BITS-1:0];
      end
   end
   assign apart_next = apart_ff || pos_ff;

   assign mul_start  = req_take;
   assign root_start = (state_ff == S_MUL) && mul_status.done && last_ff;

   always_comb begin
      state_in       = state_ff;
      sum_in         = sum_ff;
      apart_in       = apart_ff;
      pos_in         = pos_ff;
      last_in        = last_ff;
      res_sum_in     = res_sum_ff;
      res_overlap_in = res_overlap_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pos_in   = gap_pos;
               last_in  = req_data.last_dim;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_status.done) begin
               if (last_ff) begin
                  // hand the pair's totals to the root stage and start a new pair
                  res_sum_in     = sum_next;
                  res_overlap_in = !apart_next;
                  sum_in         = '0;
                  apart_in       = 1'b0;
                  state_in       = S_ROOT;
               end else begin
                  sum_in   = sum_next;
                  apart_in = apart_next;
                  state_in = S_IDLE;
               end
            end
         end
         S_ROOT, S_HOLD: begin
            if ((state_ff == S_HOLD) || root_status.done) begin
               if (out_free) begin
                  rsp_valid_in                 = 1'b1;
                  rsp_data_in.squared_distance = res_sum_ff;
                  rsp_data_in.distance_q8      = root;
                  rsp_data_in.overlap          = res_overlap_ff;
                  state_in                     = S_IDLE;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         apart_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         apart_ff     <= apart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff         <= pos_in;
      last_ff        <= last_in;
      res_sum_ff     <= res_sum_in;
      res_overlap_ff <= res_overlap_in;
      rsp_data_ff    <= rsp_data_in;
   end

   bmd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .gap     (gap[bmd_pkg::GAP_BITS-1:0]),
      .status  (mul_status),
      .product (product)
   );

   // radicand is the new sum shifted up by 16 for the q8 root
   bmd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand ({sum_next, {bmd_pkg::FRAC_SHIFT{1'b0}}}),
      .status   (root_status),
      .root     (root)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/bmd_mul.sv
// radix-4 digit-serial squarer for one gap magnitude
// depends on bmd_pkg
`timescale 1ns / 1ps

module bmd_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bmd_pkg::GAP_BITS-1:0]    gap,
   output bmd_pkg::unit_status_type        status,
   output logic [bmd_pkg::PROD_BITS-1:0]   product
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [bmd_pkg::MUL_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [bmd_pkg::GAP_BITS-1:0]        mcand_ff, mcand_in;
   logic [bmd_pkg::GAP_BITS+1:0]        mcand3_ff, mcand3_in;
   logic [bmd_pkg::GAP_BITS-1:0]        mplier_ff, mplier_in;
   logic [bmd_pkg::PROD_BITS-1:0]       acc_ff, acc_in;
   logic [bmd_pkg::GAP_BITS+1:0]        part;

   // partial product for the top two multiplier bits
   always_comb begin
      case (mplier_ff[bmd_pkg::GAP_BITS-1 -: 2])
         2'd0:    part = '0;
         2'd1:    part = {2'b00, mcand_ff};
         2'd2:    part = {1'b0, mcand_ff, 1'b0};
         2'd3:    part = mcand3_ff;
         default: part = '0;
      endcase
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mcand3_in = mcand3_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = gap;
         mcand3_in = {2'b00, gap} + {1'b0, gap, 1'b0};
         mplier_in = gap;
         acc_in    = '0;
      end else if (busy_ff) begin
         // msb-first: acc = 4*acc + digit*gap
         acc_in    = {acc_ff[bmd_pkg::PROD_BITS-3:0], 2'b00}
                     + {{(bmd_pkg::PROD_BITS-bmd_pkg::GAP_BITS-2){1'b0}}, part};
         mplier_in = {mplier_ff[bmd_pkg::GAP_BITS-3:0], 2'b00};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == bmd_pkg::MUL_CNT_BITS'(bmd_pkg::MUL_DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mcand3_ff <= mcand3_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

// File: src/bmd_sqrt.sv
// bit-serial restoring square root, one root bit per cycle
// depends on bmd_pkg
`timescale 1ns / 1ps

module bmd_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bmd_pkg::RAD_BITS-1:0]    radicand,
   output bmd_pkg::unit_status_type        status,
   output logic [bmd_pkg::ROOT_BITS-1:0]   root
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [bmd_pkg::ROOT_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [bmd_pkg::RAD_BITS-1:0]        rad_ff, rad_in;
   logic [bmd_pkg::REM_BITS-1:0]        rem_ff, rem_in;
   logic [bmd_pkg::ROOT_BITS-1:0]       root_ff, root_in;
   logic [bmd_pkg::REM_BITS-1:0]        rem_sh;
   logic [bmd_pkg::REM_BITS-1:0]        trial;

   // remainder never exceeds 2*root, so its top two bits are free for the shift
   assign rem_sh = {rem_ff[bmd_pkg::REM_BITS-3:0], rad_ff[bmd_pkg::RAD_BITS-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[bmd_pkg::RAD_BITS-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[bmd_pkg::ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[bmd_pkg::ROOT_BITS-2:0], 1'b0};
         end
         if (cnt_ff == bmd_pkg::ROOT_CNT_BITS'(bmd_pkg::ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

// File: src/bmd_checker.sv
// port-level checks for the box minimum-distance core, bound to the top level
// depends on bmd_pkg and box_min_distance_overlap_core
`timescale 1ns / 1ps

module bmd_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  bmd_pkg::rsp_data_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // overlap exactly when no positive gap contributed
   a_overlap_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.overlap == (rsp_data.squared_distance == '0)))
      else $error("overlap flag disagrees with squared distance");

   // zero distance has zero root
   a_zero_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.squared_distance == '0) |-> (rsp_data.distance_q8 == '0))
      else $error("nonzero root of zero distance");

   // a taken request keeps the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request port ready right after a request");

endmodule

bind box_min_distance_overlap_core bmd_checker u_bmd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: bench/tb_box_min_distance_overlap_core.sv
// self-checking bench for box_min_distance_overlap_core: directed rows, then random box pairs
// depends on bmd_pkg and the core; expected responses: in-bench predictor or typed rows
`timescale 1ns / 1ps

module tb_box_min_distance_overlap_core;

   localparam logic signed [bmd_pkg::COORD_BITS-1:0] COORD_MIN =
      {1'b1, {(bmd_pkg::COORD_BITS-1){1'b0}}};
   localparam logic signed [bmd_pkg::COORD_BITS-1:0] COORD_MAX =
      {1'b0, {(bmd_pkg::COORD_BITS-1){1'b1}}};

   localparam int unsigned RANDOM_ITEMS   = 420;
   localparam int unsigned PRESSURE_AT    = 25;    // response count that starts the long hold
   localparam int unsigned PRESSURE_HOLD  = 400;   // cycles the receiver holds off
   localparam int unsigned DRAIN_CYCLES   = 60;    // settle time after the last expected response
   localparam int unsigned WATCHDOG_LIMIT = 2000;  // well above the hold plus one pair of latency

   // one directed row; copies repeats the row, last_dim only on the final copy
   typedef struct packed {
      bmd_pkg::req_data_type stim;
      logic [5:0]            copies;
      logic                  has_typed;
      bmd_pkg::rsp_data_type typed;
   } directed_row_type;

   typedef enum logic [1:0] {
      SHAPE_RAW,
      SHAPE_OVERLAP,
      SHAPE_APART,
      SHAPE_EXTREME
   } dim_shape_type;

   // expected values typed in only where they can be read off directly
   localparam directed_row_type DIRECTED_ROWS [11] = '{
      // intersecting boxes
      '{'{16'sd0, 16'sd10, 16'sd5, 16'sd15, 1'b1}, 6'd1, 1'b1, '{36'd0, 26'd0, 1'b1}},
      // touching boxes, zero gap is not apart
      '{'{16'sd0, 16'sd5, 16'sd5, 16'sd9, 1'b1}, 6'd1, 1'b1, '{36'd0, 26'd0, 1'b1}},
      // both boxes span the whole range
      '{'{COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1}, 6'd1, 1'b1,
        '{36'd0, 26'd0, 1'b1}},
      // widest possible gap, 65535
      '{'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1}, 6'd1, 1'b1,
        '{36'd4294836225, 26'd16776960, 1'b0}},
      // box a inverted, taken as given: gap 10 - (-10)
      '{'{16'sd10, -16'sd10, 16'sd0, 16'sd0, 1'b1}, 6'd1, 1'b1, '{36'd400, 26'd5120, 1'b0}},
      // two dimensions, gaps 3 and 4
      '{'{16'sd0, 16'sd1, 16'sd4, 16'sd9, 1'b0}, 6'd1, 1'b0, '{36'd0, 26'd0, 1'b0}},
      '{'{16'sd0, 16'sd2, 16'sd6, 16'sd8, 1'b1}, 6'd1, 1'b1, '{36'd25, 26'd1280, 1'b0}},
      // apart in one dimension, overlapping in the next
      '{'{16'sd0, 16'sd1, 16'sd4, 16'sd9, 1'b0}, 6'd1, 1'b0, '{36'd0, 26'd0, 1'b0}},
      '{'{16'sd0, 16'sd10, 16'sd5, 16'sd15, 1'b1}, 6'd1, 1'b1, '{36'd9, 26'd768, 1'b0}},
      // negative coordinates, b below a
      '{'{-16'sd3, -16'sd1, -16'sd20, -16'sd7, 1'b1}, 6'd1, 1'b0, '{36'd0, 26'd0, 1'b0}},
      // 17 widest gaps: the sum saturates
      '{'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1}, 6'd17, 1'b1,
        '{bmd_pkg::SUM_MAX, {bmd_pkg::ROOT_BITS{1'b1}}, 1'b0}}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   bmd_pkg::req_data_type req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   bmd_pkg::rsp_data_type rsp_data;

   // predictor state for the box pair in progress
   longint       gap_square_total;
   bit           pair_apart;
   logic [4:0]   dims_in_pair;

   bmd_pkg::rsp_data_type expected_distances [$];
   int unsigned           mismatches;

   box_min_distance_overlap_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // folds one dimension into the pair; returns 1 with the response on the last one
   function automatic bit fold_dimension(input bmd_pkg::req_data_type d,
                                         output bmd_pkg::rsp_data_type r);
      longint                        lo_max;
      longint                        hi_min;
      longint                        gap;
      longint unsigned               radicand;
      longint unsigned               trial;
      logic [bmd_pkg::ROOT_BITS-1:0] root;
      r      = '0;
      lo_max = (d.box_a_low > d.box_b_low) ? d.box_a_low : d.box_b_low;
      hi_min = (d.box_a_high < d.box_b_high) ? d.box_a_high : d.box_b_high;
      gap    = lo_max - hi_min;
      if (gap > 0) begin
         // saturating accumulate
         if (gap_square_total + gap * gap > longint'(bmd_pkg::SUM_MAX))
            gap_square_total = longint'(bmd_pkg::SUM_MAX);
         else
            gap_square_total = gap_square_total + gap * gap;
         pair_apart = 1'b1;
      end
      if (dims_in_pair != 5'd31)
         dims_in_pair = dims_in_pair + 5'd1;
      if (!d.last_dim)
         return 1'b0;
      // floor root of sum << 16, settled one bit at a time from the top
      radicand = longint'(gap_square_total) << bmd_pkg::FRAC_SHIFT;
      root     = '0;
      for (int b = bmd_pkg::ROOT_BITS - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand)
            root[b] = 1'b1;
      end
      r.squared_distance = gap_square_total[bmd_pkg::SUM_BITS-1:0];
      r.distance_q8      = root;
      r.overlap          = !pair_apart;
      gap_square_total   = 0;
      pair_apart         = 1'b0;
      dims_in_pair       = '0;
      return 1'b1;
   endfunction

   function automatic logic signed [bmd_pkg::COORD_BITS-1:0] to_coord(input int v);
      if (v > COORD_MAX)
         return COORD_MAX;
      if (v < COORD_MIN)
         return COORD_MIN;
      return v[bmd_pkg::COORD_BITS-1:0];
   endfunction

   function automatic logic signed [bmd_pkg::COORD_BITS-1:0] extreme_coord();
      case ($urandom_range(0, 4))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         3: return '1;
         default: return to_coord(int'($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   // offers one dimension after an idle gap, waits for acceptance, then predicts;
   // valid stays high into the next call when that call has no gap
   task automatic offer_dimension(input bmd_pkg::req_data_type d,
                                  input int unsigned idle_cycles,
                                  input bit use_typed, input bmd_pkg::rsp_data_type typed);
      bmd_pkg::rsp_data_type predicted;
      if (idle_cycles > 0) begin
         req_valid <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      req_data  <= d;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (fold_dimension(d, predicted))
         expected_distances.push_back(use_typed ? typed : predicted);
   endtask

   // request side: reset, directed rows, then random box pairs
   initial begin : stimulus
      directed_row_type      row;
      bmd_pkg::req_data_type d;
      dim_shape_type         shape;
      int unsigned   random_sent;
      int unsigned   pick;
      int unsigned   pair_dims;
      bit            pair_overlaps;
      bit            no_gaps;
      bit            swap;
      int            center;
      int            span;
      logic signed [bmd_pkg::COORD_BITS-1:0] lo1, hi1, lo2, hi2;

      gap_square_total = 0;
      pair_apart       = 1'b0;
      dims_in_pair     = '0;
      mismatches       = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         row = DIRECTED_ROWS[i];
         for (int k = 0; k < int'(row.copies); k++) begin
            d          = row.stim;
            d.last_dim = row.stim.last_dim && (k == int'(row.copies) - 1);
            offer_dimension(d, $urandom_range(0, 6), row.has_typed && d.last_dim, row.typed);
         end
      end

      // random part: whole box pairs, mostly short, a few long enough to saturate
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            pair_dims = $urandom_range(1, 4);
         else if (pick < 95)
            pair_dims = $urandom_range(5, 16);
         else
            pair_dims = $urandom_range(17, 40);
         // some pairs overlap in every dimension so the overlap flag is exercised
         pair_overlaps = ($urandom_range(0, 9) < 3);
         no_gaps       = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < int'(pair_dims); k++) begin
            shape  = pair_overlaps ? SHAPE_OVERLAP : dim_shape_type'($urandom_range(0, 3));
            center = int'($urandom_range(0, 65535)) - 32768;
            span   = 1 << $urandom_range(0, 15);
            case (shape)
               SHAPE_RAW: begin
                  d.box_a_low  = to_coord(int'($urandom_range(0, 65535)) - 32768);
                  d.box_a_high = to_coord(int'($urandom_range(0, 65535)) - 32768);
                  d.box_b_low  = to_coord(int'($urandom_range(0, 65535)) - 32768);
                  d.box_b_high = to_coord(int'($urandom_range(0, 65535)) - 32768);
               end
               SHAPE_OVERLAP: begin
                  // both boxes contain center, touching now and then
                  d.box_a_low  = to_coord(center - int'($urandom_range(0, span)));
                  d.box_a_high = to_coord(center + int'($urandom_range(0, span)));
                  d.box_b_low  = to_coord(center - int'($urandom_range(0, span)));
                  d.box_b_high = to_coord(center + int'($urandom_range(0, span)));
                  if ($urandom_range(0, 5) == 0) begin
                     d.box_a_high = to_coord(center);
                     d.box_b_low  = to_coord(center);
                  end
               end
               SHAPE_APART: begin
                  // one box ends at center, the other starts past it unless clipped at the top
                  lo1  = to_coord(center - int'($urandom_range(0, span)));
                  hi1  = to_coord(center);
                  lo2  = to_coord(center + int'($urandom_range(1, span)));
                  hi2  = to_coord(int'(lo2) + int'($urandom_range(0, span)));
                  swap = $urandom_range(0, 1);
                  d.box_a_low  = swap ? lo2 : lo1;
                  d.box_a_high = swap ? hi2 : hi1;
                  d.box_b_low  = swap ? lo1 : lo2;
                  d.box_b_high = swap ? hi1 : hi2;
               end
               default: begin
                  d.box_a_low  = extreme_coord();
                  d.box_a_high = extreme_coord();
                  d.box_b_low  = extreme_coord();
                  d.box_b_high = extreme_coord();
               end
            endcase
            d.last_dim = (k == int'(pair_dims) - 1);
            offer_dimension(d, no_gaps ? 0 : $urandom_range(0, 6), 1'b0, '0);
            random_sent++;
         end
      end
      req_valid <= 1'b0;

      // wait for every expected response, then let the core settle
      while (expected_distances.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // response side: random hold-offs per response, zero-hold stretches,
   // and one long hold so the output register fills and the core stalls requests
   initial begin : receiver
      bmd_pkg::rsp_data_type want;
      int unsigned  results_taken;
      int unsigned  hold;
      results_taken = 0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (results_taken == PRESSURE_AT)
            hold = PRESSURE_HOLD;
         else if ((results_taken % 32) < 8)
            hold = 0;
         else
            hold = $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         results_taken++;
         if (expected_distances.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_data);
            mismatches++;
         end else begin
            want = expected_distances.pop_front();
            if (rsp_data.squared_distance !== want.squared_distance) begin
               $error("squared_distance: expected %0d, got %0d",
                      want.squared_distance, rsp_data.squared_distance);
               mismatches++;
            end
            if (rsp_data.distance_q8 !== want.distance_q8) begin
               $error("distance_q8: expected %0d, got %0d",
                      want.distance_q8, rsp_data.distance_q8);
               mismatches++;
            end
            if (rsp_data.overlap !== want.overlap) begin
               $error("overlap: expected %0b, got %0b", want.overlap, rsp_data.overlap);
               mismatches++;
            end
         end
      end
   end

   // ends the run when neither channel moves for too long
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

endmodule
